// ===== hdl/htmp_pkg.sv =====
// Package for the hex telemetry message parser.
// Holds the prefix codes, character constants, result type and hex digit decode.
`default_nettype none

package htmp_pkg;

    typedef enum logic [1:0] {
        PFX_NONE  = 2'd0,
        PFX_SHOT  = 2'd1,
        PFX_STATE = 2'd2,
        PFX_OPEN  = 2'd3
    } t_prefix;

    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_SHOT  = 8'h4D;
    localparam logic [7:0] CH_STATE = 8'h4E;

    localparam logic [3:0] POS_MAX        = 4'd15;
    localparam logic [3:0] PREFIX_LEN     = 4'd3;
    localparam logic [3:0] SHOT_MIN_LEN   = 4'd15;
    localparam logic [3:0] STATE_MIN_LEN  = 4'd7;
    localparam logic [3:0] PRESSURE_FIRST = 4'd7;
    localparam logic [3:0] PRESSURE_LAST  = 4'd10;
    localparam logic [3:0] FLOW_FIRST     = 4'd11;
    localparam logic [3:0] STATE_FIRST    = 4'd3;
    localparam logic [3:0] STATE_LAST     = 4'd4;
    localparam logic [3:0] SUB_FIRST      = 4'd5;
    localparam logic [3:0] SUB_LAST       = 4'd6;

    localparam logic [7:0] IDLE_CODE        = 8'd2;
    localparam logic [7:0] NO_SUBSTATE_CODE = 8'd0;

    localparam int unsigned OUT_DATA_W = 72;
    localparam int unsigned OUT_USER_W = 2;

    typedef struct packed {
        t_prefix     kind;
        logic        updated;
        logic [15:0] pressure;
        logic [15:0] flow;
        logic [7:0]  state;
        logic [7:0]  substate;
        logic [7:0]  prev_state;
        logic [7:0]  prev_substate;
    } t_result;

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        d = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = {1'b0, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = {1'b0, 4'(c - 8'h57)};
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/hex_telemetry_message_parser.sv =====
// Hex telemetry message parser top level: input register, decoder, result register.
// Depends on htmp_pkg and htmp_core.
// The last byte passes the input register and decoder into the result register, which presents the result.
// Throughput: 1 byte per cycle, set by the single decode pass, except a last byte waits on an untaken result.
// Reset: synchronous, active low; clears both stages and restores stored values.
`default_nettype none

module hex_telemetry_message_parser
    import htmp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,  // msg_byte
    input  wire logic                  s_axis_tlast,  // end_of_message
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // any_updated, pressure_value, flow_value, machine_state, machine_substate,
    // previous_state, previous_substate, zero fill
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic [OUT_USER_W-1:0]      m_axis_tuser   // message_kind
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    t_result    w_result;
    logic       w_advance;
    logic       w_load;

    assign w_advance     = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign w_load        = w_advance && r_in_last;
    assign s_axis_tready = !r_in_valid || w_advance;

    htmp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_load) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {7'd0, r_out.prev_substate, r_out.prev_state, r_out.substate,
                            r_out.state, r_out.flow, r_out.pressure, r_out.updated};

`ifndef SYNTHESIS
    a_kind_never_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_out.kind != PFX_OPEN)
        else $error("open prefix code reached the output");
    a_update_needs_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_out.updated |-> r_out.kind != PFX_NONE)
        else $error("update reported for unrecognized message");
    a_midbyte_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && !r_in_last && !r_out_valid |=> !r_out_valid)
        else $error("result produced for a byte that is not the last");
    a_input_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_last))
        else $error("input register lost a stalled byte");
`endif

endmodule

`default_nettype wire

// ===== hdl/htmp_core.sv =====
// Per-byte decoder of the hex telemetry message parser: message tracking and stored values.
// Depends on htmp_pkg.
`default_nettype none

module htmp_core
    import htmp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    output t_result         o_result
);

    logic [3:0]  r_pos,        n_pos;
    t_prefix     r_prefix,     n_prefix;
    logic [15:0] r_acc_a,      n_acc_a;
    logic        r_ok_a,       n_ok_a;
    logic [15:0] r_acc_b,      n_acc_b;
    logic        r_ok_b,       n_ok_b;
    logic [15:0] r_pressure,   n_pressure;
    logic [15:0] r_flow,       n_flow;
    logic [7:0]  r_state,      n_state;
    logic [7:0]  r_sub,        n_sub;
    logic [7:0]  r_prev_state, n_prev_state;
    logic [7:0]  r_prev_sub,   n_prev_sub;

    logic [4:0] w_dig;
    logic [3:0] w_val;
    logic       w_feed_a;
    logic       w_feed_b;
    t_prefix    w_kind;
    logic       w_updated;

    assign w_dig = hex_digit(i_byte);
    assign w_val = w_dig[4] ? 4'd0 : w_dig[3:0];

    always_comb begin
        n_prefix  = r_prefix;
        w_feed_a  = 1'b0;
        w_feed_b  = 1'b0;
        if (r_pos == 4'd0) begin
            n_prefix = (i_byte == CH_OPEN) ? PFX_OPEN : PFX_NONE;
        end else if (r_pos == 4'd1) begin
            if (r_prefix == PFX_OPEN && i_byte == CH_SHOT) begin
                n_prefix = PFX_SHOT;
            end else if (r_prefix == PFX_OPEN && i_byte == CH_STATE) begin
                n_prefix = PFX_STATE;
            end else begin
                n_prefix = PFX_NONE;
            end
        end else if (r_pos == 4'd2) begin
            if (i_byte != CH_CLOSE) begin
                n_prefix = PFX_NONE;
            end
        end else if (r_pos != POS_MAX) begin
            if (r_prefix == PFX_SHOT) begin
                w_feed_a = (r_pos >= PRESSURE_FIRST) && (r_pos <= PRESSURE_LAST);
                w_feed_b = (r_pos >= FLOW_FIRST);
            end else if (r_prefix == PFX_STATE) begin
                w_feed_a = (r_pos >= STATE_FIRST) && (r_pos <= STATE_LAST);
                w_feed_b = (r_pos >= SUB_FIRST) && (r_pos <= SUB_LAST);
            end
        end
    end

    always_comb begin
        n_acc_a = w_feed_a ? {r_acc_a[11:0], w_val} : r_acc_a;
        n_ok_a  = r_ok_a & ~(w_feed_a & w_dig[4]);
        n_acc_b = w_feed_b ? {r_acc_b[11:0], w_val} : r_acc_b;
        n_ok_b  = r_ok_b & ~(w_feed_b & w_dig[4]);
        n_pos   = (r_pos == POS_MAX) ? POS_MAX : r_pos + 4'd1;
    end

    always_comb begin
        n_pressure   = r_pressure;
        n_flow       = r_flow;
        n_state      = r_state;
        n_sub        = r_sub;
        n_prev_state = r_prev_state;
        n_prev_sub   = r_prev_sub;
        w_updated    = 1'b0;
        w_kind       = PFX_NONE;
        if (n_pos >= PREFIX_LEN && (n_prefix == PFX_SHOT || n_prefix == PFX_STATE)) begin
            w_kind = n_prefix;
        end
        if (w_kind == PFX_SHOT && n_pos >= SHOT_MIN_LEN) begin
            if (n_ok_a) begin
                n_pressure = n_acc_a;
                w_updated  = 1'b1;
            end
            if (n_ok_b) begin
                n_flow    = n_acc_b;
                w_updated = 1'b1;
            end
        end else if (w_kind == PFX_STATE && n_pos >= STATE_MIN_LEN) begin
            if (n_ok_a && n_acc_a[7:0] != r_state) begin
                n_prev_state = r_state;
                n_state      = n_acc_a[7:0];
                w_updated    = 1'b1;
            end
            if (n_ok_b && n_acc_b[7:0] != r_sub) begin
                n_prev_sub = r_sub;
                n_sub      = n_acc_b[7:0];
                w_updated  = 1'b1;
            end
        end
    end

    always_comb begin
        o_result.kind          = w_kind;
        o_result.updated       = w_updated;
        o_result.pressure      = n_pressure;
        o_result.flow          = n_flow;
        o_result.state         = n_state;
        o_result.substate      = n_sub;
        o_result.prev_state    = n_prev_state;
        o_result.prev_substate = n_prev_sub;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= 4'd0;
            r_prefix     <= PFX_NONE;
            r_acc_a      <= 16'd0;
            r_ok_a       <= 1'b1;
            r_acc_b      <= 16'd0;
            r_ok_b       <= 1'b1;
            r_pressure   <= 16'd0;
            r_flow       <= 16'd0;
            r_state      <= IDLE_CODE;
            r_sub        <= NO_SUBSTATE_CODE;
            r_prev_state <= 8'd0;
            r_prev_sub   <= 8'd0;
        end else if (i_step) begin
            if (i_last) begin
                r_pos        <= 4'd0;
                r_prefix     <= PFX_NONE;
                r_acc_a      <= 16'd0;
                r_ok_a       <= 1'b1;
                r_acc_b      <= 16'd0;
                r_ok_b       <= 1'b1;
                r_pressure   <= n_pressure;
                r_flow       <= n_flow;
                r_state      <= n_state;
                r_sub        <= n_sub;
                r_prev_state <= n_prev_state;
                r_prev_sub   <= n_prev_sub;
            end else begin
                r_pos    <= n_pos;
                r_prefix <= n_prefix;
                r_acc_a  <= n_acc_a;
                r_ok_a   <= n_ok_a;
                r_acc_b  <= n_acc_b;
                r_ok_b   <= n_ok_b;
            end
        end
    end

`ifndef SYNTHESIS
    a_pos_cleared_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_last |=> r_pos == 4'd0 && r_ok_a && r_ok_b)
        else $error("message state not cleared after last byte");
    a_state_change_moves_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_last && n_state != r_state |=> r_prev_state == $past(r_state))
        else $error("previous state not captured on state change");
    a_no_store_midmessage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_last |=> $stable(r_pressure) && $stable(r_flow) && $stable(r_state))
        else $error("stored value changed before message end");
`endif

endmodule

`default_nettype wire
